// ===== rtl/core/aes_pkg.sv =====
// Shared constants, types and helpers for the auto exposure stepper.
package aes_pkg;

    localparam int SUM_W     = 30;
    localparam int CNT_W     = 23;
    localparam int PIX_W     = 8;
    localparam int EXP_W     = 6;
    localparam int QUO_W     = 8;
    localparam int DIV_STEPS = QUO_W + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] MAX_PIXELS    = CNT_W'(4194304);
    localparam logic [EXP_W-1:0] EXP_MIN       = EXP_W'(10);
    localparam logic [EXP_W-1:0] EXP_MAX       = EXP_W'(60);
    localparam logic [EXP_W-1:0] EXP_JUMP_FROM = EXP_W'(32);
    localparam logic [EXP_W-1:0] EXP_JUMP_TO   = EXP_W'(52);
    localparam logic [EXP_W-1:0] EXP_RESET     = EXP_W'(32);
    localparam logic [PIX_W-1:0] ERR_BAND      = PIX_W'(10);
    localparam logic [PIX_W-1:0] TARGET_RESET  = PIX_W'(70);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE
    } aes_state_t;

    // Frame totals handed from the accumulator to the divider
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } frame_tot_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] mean;
    } div_stat_t;

    // Decision result for one frame
    typedef struct packed {
        logic [EXP_W-1:0] exposure;
        logic             changed;
        logic             adjusting;
    } expo_res_t;

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        begin
            m = (a > b) ? a : b;
            return (m > c) ? m : c;
        end
    endfunction

endpackage

// ===== rtl/core/auto_exposure_stepper.sv =====
// Auto exposure stepper top level: sequencer, target register, result register.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready    red, green, blue, frame_end
//   out       output     out_valid / out_ready  exposure, exposure_changed,
//                                               mean_brightness, adjusting
//   cfg       input      cfg_wr_en              cfg_wr_data (target brightness)
//
// A pixel without frame_end is accepted while idle. A frame_end pixel passes through
// the request, nine compare and subtract steps of the shared divider, the collection
// of the quotient and the exposure decision.
// The decision waits while a previous result still sits in the output register.
// Reset gives target 70, exposure 32, adjustment idle and empty totals.
module auto_exposure_stepper (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [aes_pkg::PIX_W-1:0] red,
    input  logic [aes_pkg::PIX_W-1:0] green,
    input  logic [aes_pkg::PIX_W-1:0] blue,
    input  logic                      frame_end,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [aes_pkg::EXP_W-1:0] exposure,
    output logic                      exposure_changed,
    output logic [aes_pkg::PIX_W-1:0] mean_brightness,
    output logic                      adjusting,
    input  logic                      cfg_wr_en,
    input  logic [aes_pkg::PIX_W-1:0] cfg_wr_data
);
    import aes_pkg::*;

    aes_state_t       state_reg, state_next;
    logic [PIX_W-1:0] target_reg;
    logic             fire;
    logic             div_start;
    logic             apply;
    logic             out_free;
    frame_tot_t       tot;
    div_stat_t        dstat;
    expo_res_t        res;

    logic             out_valid_reg, out_valid_next;
    logic [EXP_W-1:0] exp_out_reg;
    logic             chg_out_reg;
    logic [PIX_W-1:0] mean_out_reg;
    logic             adj_out_reg;

    assign fire     = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    aes_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .frame_end (frame_end),
        .tot       (tot)
    );

    aes_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .tot   (tot),
        .stat  (dstat)
    );

    aes_expo u_expo (
        .clk    (clk),
        .rst_n  (rst_n),
        .apply  (apply),
        .mean   (dstat.mean),
        .target (target_reg),
        .res    (res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire && frame_end)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (dstat.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        apply     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = fire && frame_end;
            end
            ST_DIVIDE:
            begin
            end
            ST_DECIDE:
            begin
                apply = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Target brightness register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (cfg_wr_en)
        begin
            target_reg <= cfg_wr_data;
        end
    end

    // Result register: load on decision, drop when the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            exp_out_reg  <= res.exposure;
            chg_out_reg  <= res.changed;
            mean_out_reg <= dstat.mean;
            adj_out_reg  <= res.adjusting;
        end
    end

    assign out_valid        = out_valid_reg;
    assign exposure         = exp_out_reg;
    assign exposure_changed = chg_out_reg;
    assign mean_brightness  = mean_out_reg;
    assign adjusting        = adj_out_reg;

endmodule

// ===== rtl/core/aes_accum.sv =====
// Per-pixel brightness accumulator: running sum and pixel count of a frame.
module aes_accum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [aes_pkg::PIX_W-1:0] red,
    input  logic [aes_pkg::PIX_W-1:0] green,
    input  logic [aes_pkg::PIX_W-1:0] blue,
    input  logic                      frame_end,
    output aes_pkg::frame_tot_t       tot
);
    import aes_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PIX_W-1:0] bright;

    // Add this pixel unless the frame is already at its pixel limit
    always_comb
    begin
        bright = max3(red, green, blue);
        tot.sum   = sum_reg;
        tot.count = count_reg;
        if (count_reg < MAX_PIXELS)
        begin
            tot.sum   = SUM_W'(sum_reg + SUM_W'(bright));
            tot.count = CNT_W'(count_reg + CNT_W'(1));
        end
    end

    // Advance on each request, clear after the frame's last pixel
    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (fire)
        begin
            if (frame_end)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = tot.sum;
                count_next = tot.count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/aes_div.sv =====
// Iterative restoring divider: one compare and subtract per cycle, result
// saturated to 255.
module aes_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  aes_pkg::frame_tot_t tot,
    output aes_pkg::div_stat_t  stat
);
    import aes_pkg::*;

    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W:0]       dsr_reg, dsr_next;
    logic [QUO_W:0]       quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic [SUM_W+1:0]     diff;
    logic                 ge;

    // Shared compare and subtract unit
    always_comb
    begin
        diff = {2'b00, rem_reg} - {1'b0, dsr_reg};
        ge   = !diff[SUM_W+1];
    end

    // Load on start, then one quotient bit per step, top bit first
    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = tot.sum;
            dsr_next  = {tot.count, {QUO_W{1'b0}}};
            quo_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
            zero_next = (tot.count == '0);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = diff[SUM_W-1:0];
            end
            quo_next  = {quo_reg[QUO_W-1:0], ge};
            dsr_next  = dsr_reg >> 1;
            step_next = STEP_W'(step_reg + STEP_W'(1));
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    // Report zero for an empty frame; saturate when the quotient needs a ninth bit
    always_comb
    begin
        stat.done = done_reg;
        if (zero_reg)
        begin
            stat.mean = '0;
        end
        else if (quo_reg[QUO_W])
        begin
            stat.mean = '1;
        end
        else
        begin
            stat.mean = quo_reg[QUO_W-1:0];
        end
    end

endmodule

// ===== rtl/core/aes_expo.sv =====
// Exposure decision: holds exposure level and adjust flag, steps at most once per frame.
module aes_expo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      apply,
    input  logic [aes_pkg::PIX_W-1:0] mean,
    input  logic [aes_pkg::PIX_W-1:0] target,
    output aes_pkg::expo_res_t        res
);
    import aes_pkg::*;

    logic [EXP_W-1:0] exp_reg, exp_next;
    logic             adj_reg, adj_next;
    logic [EXP_W-1:0] exp_step;
    logic [PIX_W-1:0] err_mag;
    logic             err_neg;
    logic             err_pos;
    logic             in_band;

    // Error sign and magnitude of target - mean
    always_comb
    begin
        err_neg = (target < mean);
        err_pos = (target > mean);
        err_mag = err_neg ? PIX_W'(mean - target) : PIX_W'(target - mean);
        in_band = (err_mag < ERR_BAND);
    end

    // Step against the error, jump on the way up, clamp to the legal range
    always_comb
    begin
        exp_step = exp_reg;
        if (err_neg)
        begin
            if (exp_reg > EXP_MIN)
            begin
                exp_step = EXP_W'(exp_reg - EXP_W'(1));
            end
        end
        else if (err_pos)
        begin
            if (exp_reg == EXP_JUMP_FROM)
            begin
                exp_step = EXP_JUMP_TO;
            end
            else if (exp_reg < EXP_MAX)
            begin
                exp_step = EXP_W'(exp_reg + EXP_W'(1));
            end
        end
        if (exp_step < EXP_MIN)
        begin
            exp_step = EXP_MIN;
        end
        if (exp_step > EXP_MAX)
        begin
            exp_step = EXP_MAX;
        end
    end

    // Idle frames only start adjustment; active frames step and may stop
    always_comb
    begin
        exp_next = exp_reg;
        adj_next = adj_reg;
        if (!adj_reg)
        begin
            adj_next = (mean != target);
        end
        else
        begin
            exp_next = exp_step;
            if ((exp_step == EXP_MIN) || (exp_step == EXP_MAX) || in_band)
            begin
                adj_next = 1'b0;
            end
        end
        res.exposure  = exp_next;
        res.changed   = (exp_next != exp_reg);
        res.adjusting = adj_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= EXP_RESET;
            adj_reg <= 1'b0;
        end
        else if (apply)
        begin
            exp_reg <= exp_next;
            adj_reg <= adj_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the auto exposure stepper with a frame-level predictor.
module tb;
    import aes_pkg::*;

    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct {
        logic [EXP_W-1:0] expo;
        logic             changed;
        logic [PIX_W-1:0] mean;
        logic             adj;
    } exposure_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
    logic             out_valid;
    logic             out_ready;
    logic [EXP_W-1:0] exposure;
    logic             exposure_changed;
    logic [PIX_W-1:0] mean_brightness;
    logic             adjusting;
    logic             cfg_wr_en;
    logic [PIX_W-1:0] cfg_wr_data;

    // Predictor state
    logic [SUM_W-1:0] sum_acc;
    logic [CNT_W-1:0] pix_cnt;
    logic [EXP_W-1:0] expo_lvl;
    logic             adj_on;
    logic [PIX_W-1:0] target_lvl;

    exposure_result_t exposure_q[$];
    int               fail_count;
    int               quiet_cycles;
    bit               tx_steady;
    bit               rx_steady;
    bit               long_hold_req;

    auto_exposure_stepper uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .frame_end        (frame_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .exposure         (exposure),
        .exposure_changed (exposure_changed),
        .mean_brightness  (mean_brightness),
        .adjusting        (adjusting),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    // Free-running clock, period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one accepted pixel into the frame totals; decide exposure on frame end
    function automatic void predict_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                          input logic [PIX_W-1:0] b, input logic fe);
        logic [PIX_W-1:0] bright;
        int unsigned      avg;
        int               err;
        logic [EXP_W-1:0] prev;
        exposure_result_t res;
        begin
            bright = (r > g) ? r : g;
            bright = (bright > b) ? bright : b;
            if (pix_cnt < MAX_PIXELS)
            begin
                sum_acc = sum_acc + SUM_W'(bright);
                pix_cnt = pix_cnt + 1'b1;
            end
            if (fe)
            begin
                avg = (pix_cnt != 0) ? 32'(sum_acc) / 32'(pix_cnt) : 0;
                if (avg > 255)
                    avg = 255;
                sum_acc = '0;
                pix_cnt = '0;
                prev = expo_lvl;
                res.changed = 1'b0;
                if (!adj_on)
                begin
                    // Idle: a mismatch only arms the loop
                    if (avg != 32'(target_lvl))
                        adj_on = 1'b1;
                end
                else
                begin
                    err = int'(target_lvl) - int'(avg);
                    if (err < 0)
                    begin
                        if (expo_lvl > EXP_MIN)
                            expo_lvl = expo_lvl - 1'b1;
                    end
                    else if (err > 0)
                    begin
                        if (expo_lvl == EXP_JUMP_FROM)
                            expo_lvl = EXP_JUMP_TO;
                        else if (expo_lvl < EXP_MAX)
                            expo_lvl = expo_lvl + 1'b1;
                    end
                    res.changed = (expo_lvl != prev);
                    if (expo_lvl == EXP_MIN || expo_lvl == EXP_MAX ||
                        (err < int'(ERR_BAND) && err > -int'(ERR_BAND)))
                        adj_on = 1'b0;
                end
                res.expo = expo_lvl;
                res.mean = avg[PIX_W-1:0];
                res.adj  = adj_on;
                exposure_q.push_back(res);
            end
        end
    endfunction

    function automatic int clamp_level(input int x);
        begin
            if (x < 0)
                return 0;
            if (x > 255)
                return 255;
            return x;
        end
    endfunction

    // Offer one pixel request and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic fe);
        int gap;
        begin
            if ($urandom_range(0, 31) == 0)
                tx_steady = !tx_steady;
            gap = tx_steady ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            red       <= r;
            green     <= g;
            blue      <= b;
            frame_end <= fe;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_pixel(r, g, b, fe);
        end
    endtask

    // Send a frame whose brightness sits near lvl, or fully random pixels when wild
    task automatic send_frame(input int npix, input int lvl, input bit wild);
        int               v;
        int               k;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        begin
            for (int i = 0; i < npix; i++)
            begin
                if (wild)
                begin
                    r = PIX_W'($urandom_range(0, 255));
                    g = PIX_W'($urandom_range(0, 255));
                    b = PIX_W'($urandom_range(0, 255));
                end
                else
                begin
                    v = clamp_level(lvl + int'($urandom_range(0, 6)) - 3);
                    k = $urandom_range(0, 2);
                    r = PIX_W'($urandom_range(0, v));
                    g = PIX_W'($urandom_range(0, v));
                    b = PIX_W'($urandom_range(0, v));
                    case (k)
                        0: r = v[PIX_W-1:0];
                        1: g = v[PIX_W-1:0];
                        default: b = v[PIX_W-1:0];
                    endcase
                end
                send_pixel(r, g, b, i == npix - 1);
            end
        end
    endtask

    // Drop valid and wait until every expected result is out
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (exposure_q.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_target(input int v);
        begin
            wait_idle();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= v[PIX_W-1:0];
            @(posedge clk);
            cfg_wr_en  <= 1'b0;
            target_lvl = v[PIX_W-1:0];
        end
    endtask

    // Mostly frames pushed steadily off target, some near it, some noise
    task automatic run_phase(input int tgt, input int n_items);
        int sent;
        int dir;
        int kind;
        int lvl;
        int npix;
        begin
            set_target(tgt);
            dir = ($urandom_range(0, 1) != 0) ? 1 : -1;
            sent = 0;
            while (sent < n_items)
            begin
                kind = $urandom_range(0, 9);
                npix = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 5);
                if (kind == 9)
                    dir = -dir;
                if (kind <= 5)
                    lvl = tgt + dir * int'($urandom_range(10, 80));
                else
                    lvl = tgt + int'($urandom_range(0, 18)) - 9;
                send_frame(npix, lvl, kind == 8);
                sent += npix;
            end
        end
    endtask

    // Walk the decision paths from reset with the reset target
    task automatic test_directed_frames();
        begin
            send_pixel(8'd0, 8'd0, 8'd0, 1'b1);         // start frame arms the loop
            send_pixel(8'd0, 8'd0, 8'd1, 1'b1);         // rising step jumps from 32
            send_pixel(8'd255, 8'd128, 8'd7, 1'b0);
            send_pixel(8'd3, 8'd255, 8'd9, 1'b0);
            send_pixel(8'd9, 8'd1, 8'd255, 1'b1);
            send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
            send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
            send_pixel(8'd1, 8'd2, 8'd3, 1'b1);         // floor mean of 258 over 3
            send_pixel(8'd75, 8'd10, 8'd20, 1'b1);      // small error: step, then stop
            send_pixel(8'd70, 8'd70, 8'd70, 1'b1);      // idle and on target
            send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
            send_pixel(8'd70, 8'd0, 8'd0, 1'b1);        // zero error while adjusting
            send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
            send_pixel(8'd0, 8'd0, 8'd2, 1'b1);
            send_pixel(8'd0, 8'd200, 8'd0, 1'b0);
            send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        end
    endtask

    task automatic test_target_extremes();
        begin
            run_phase(0, 80);
            run_phase(255, 80);
        end
    endtask

    // Hold off the result side so the block fills and stalls its input
    task automatic test_output_stall();
        begin
            wait_idle();
            long_hold_req = 1'b1;
            tx_steady = 1'b1;
            repeat (20) send_frame($urandom_range(1, 2), $urandom_range(0, 255), 1'b0);
            tx_steady = 1'b0;
        end
    endtask

    task automatic test_random_targets();
        begin
            run_phase(int'(TARGET_RESET), 90);
            repeat (6) run_phase($urandom_range(0, 255), 90);
        end
    endtask

    // Accept and check results; draw a hold-off before each next result
    initial
    begin : result_checker
        exposure_result_t want;
        int               hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (exposure_q.size() == 0)
                begin
                    $error("result with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = exposure_q.pop_front();
                    if (exposure !== want.expo)
                    begin
                        $error("exposure: expected %0d, got %0d", want.expo, exposure);
                        fail_count++;
                    end
                    if (exposure_changed !== want.changed)
                    begin
                        $error("exposure_changed: expected %0d, got %0d",
                               want.changed, exposure_changed);
                        fail_count++;
                    end
                    if (mean_brightness !== want.mean)
                    begin
                        $error("mean_brightness: expected %0d, got %0d",
                               want.mean, mean_brightness);
                        fail_count++;
                    end
                    if (adjusting !== want.adj)
                    begin
                        $error("adjusting: expected %0d, got %0d", want.adj, adjusting);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rx_steady = !rx_steady;
                hold_left = rx_steady ? 0 : $urandom_range(0, 7);
            end
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        fail_count    = 0;
        quiet_cycles  = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        long_hold_req = 1'b0;
        sum_acc       = '0;
        pix_cnt       = '0;
        expo_lvl      = EXP_RESET;
        adj_on        = 1'b0;
        target_lvl    = TARGET_RESET;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        red         <= '0;
        green       <= '0;
        blue        <= '0;
        frame_end   <= 1'b0;
        out_ready   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_target_extremes();
        test_output_stall();
        test_random_targets();

        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== auto_exposure_stepper.f =====
rtl/core/aes_pkg.sv
rtl/core/aes_accum.sv
rtl/core/aes_div.sv
rtl/core/aes_expo.sv
rtl/core/auto_exposure_stepper.sv
verif/tb.sv
